// ----- src/sft_pkg.sv -----
`timescale 1ns / 1ps
package sft_pkg;

  localparam int Lanes    = 5;
  localparam int NumW     = 32;
  localparam int DenW     = 16;
  localparam int SqW      = 32;
  localparam int RootW    = 16;
  localparam int SqRemW   = 17;
  localparam int SqCells  = SqW / 2;
  localparam int DivCells = NumW;

  localparam int LaneDirX  = 0;
  localparam int LaneDirY  = 1;
  localparam int LaneDirZ  = 2;
  localparam int LaneSideX = 3;
  localparam int LaneSideY = 4;

  typedef struct packed {
    logic                              vld;
    logic [SqW-1:0]                    sqv;
    logic [SqRemW-1:0]                 sqrem;
    logic [RootW-1:0]                  root;
    logic [Lanes-1:0][NumW-1:0]        num;
    logic [Lanes-1:0][DenW-1:0]        rem;
    logic [Lanes-1:0]                  neg;
    logic [DenW-1:0]                   ls;
    logic [23:0]                       mid_x;
    logic [23:0]                       mid_y;
    logic [19:0]                       mid_z;
  } sft_item_t;

endpackage

// ----- src/sft_front.sv -----
`timescale 1ns / 1ps
module sft_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   valid,
  input  logic signed [15:0]     start_x,
  input  logic signed [15:0]     start_y,
  input  logic signed [15:0]     start_z,
  input  logic signed [15:0]     end_x,
  input  logic signed [15:0]     end_y,
  input  logic signed [15:0]     end_z,
  input  logic [15:0]            length_scale,
  input  logic [15:0]            width_scale,
  output sft_pkg::sft_item_t     item
);
  import sft_pkg::*;

  // stage 1: deltas and midpoints
  logic               v1;
  logic signed [16:0] dx, dy, dz;
  logic [15:0]        ls1, ws1;
  logic [23:0]        mx1, my1;
  logic [19:0]        mz1;
  logic signed [16:0] sum_x, sum_y, sum_z;
  logic signed [15:0] half_x, half_y, half_z;

  // stage 2: products
  logic               v2;
  logic [31:0]        sqx, sqy, px, py;
  logic signed [16:0] dx2, dy2, dz2;
  logic [15:0]        ls2;
  logic [23:0]        mx2, my2;
  logic [19:0]        mz2;
  logic signed [33:0] sqx_full, sqy_full;
  logic signed [33:0] px_full, py_full;

  logic signed [28:0] nx, ny;
  logic [31:0]        sq_sum;

  always_comb begin
    sum_x  = 17'(start_x) + 17'(end_x);
    sum_y  = 17'(start_y) + 17'(end_y);
    sum_z  = 17'(start_z) + 17'(end_z);
    half_x = 16'((sum_x + 17'(sum_x[16])) >>> 1);
    half_y = 16'((sum_y + 17'(sum_y[16])) >>> 1);
    half_z = 16'((sum_z + 17'(sum_z[16])) >>> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= valid;
      v2 <= v1;
    end
    if (en) begin
      dx  <= 17'(end_x) - 17'(start_x);
      dy  <= 17'(end_y) - 17'(start_y);
      dz  <= 17'(end_z) - 17'(start_z);
      ls1 <= length_scale;
      ws1 <= width_scale;
      mx1 <= {half_x, 8'd0};
      my1 <= {half_y, 8'd0};
      mz1 <= {half_z, 4'd0};
    end
  end

  always_comb begin
    sqx_full = 34'(dx) * 34'(dx);
    sqy_full = 34'(dy) * 34'(dy);
    px_full  = 34'(dy) * $signed({18'd0, ws1});
    py_full  = 34'(dx) * $signed({18'd0, ws1});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= sqx_full[31:0];
      sqy <= sqy_full[31:0];
      px  <= 32'd0 - px_full[31:0];
      py  <= py_full[31:0];
      dx2 <= dx;
      dy2 <= dy;
      dz2 <= dz;
      ls2 <= ls1;
      mx2 <= mx1;
      my2 <= my1;
      mz2 <= mz1;
    end
  end

  always_comb begin
    nx     = {dx2, 12'd0};
    ny     = {dy2, 12'd0};
    sq_sum = sqx + sqy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item.vld <= 1'b0;
    end else if (en) begin
      item.vld <= v2;
    end
    if (en) begin
      item.sqv   <= sq_sum;
      item.sqrem <= '0;
      item.root  <= '0;
      item.rem   <= '0;
      item.neg[LaneDirX]  <= nx[28];
      item.neg[LaneDirY]  <= ny[28];
      item.neg[LaneDirZ]  <= dz2[16];
      item.neg[LaneSideX] <= px[31];
      item.neg[LaneSideY] <= py[31];
      item.num[LaneDirX]  <= nx[28] ? 32'd0 - 32'(nx) : 32'(nx);
      item.num[LaneDirY]  <= ny[28] ? 32'd0 - 32'(ny) : 32'(ny);
      item.num[LaneDirZ]  <= dz2[16] ? 32'd0 - 32'(dz2) : 32'(dz2);
      item.num[LaneSideX] <= px[31] ? 32'd0 - px : px;
      item.num[LaneSideY] <= py[31] ? 32'd0 - py : py;
      item.ls    <= ls2;
      item.mid_x <= mx2;
      item.mid_y <= my2;
      item.mid_z <= mz2;
    end
  end

endmodule

// ----- src/sft_sqrt_cell.sv -----
`timescale 1ns / 1ps
module sft_sqrt_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  sft_pkg::sft_item_t d,
  output sft_pkg::sft_item_t q
);
  import sft_pkg::*;

  logic [SqRemW+1:0] rem2;
  logic [SqRemW+1:0] trial;
  logic              ge;
  sft_item_t         q_next;

  always_comb begin
    rem2   = {d.sqrem, d.sqv[SqW-1 -: 2]};
    trial  = {1'b0, d.root, 2'b01};
    ge     = (rem2 >= trial);
    q_next = d;
    q_next.sqv   = {d.sqv[SqW-3:0], 2'b00};
    q_next.sqrem = ge ? SqRemW'(rem2 - trial) : SqRemW'(rem2);
    q_next.root  = {d.root[RootW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

// ----- src/sft_div_cell.sv -----
`timescale 1ns / 1ps
module sft_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  sft_pkg::sft_item_t d,
  output sft_pkg::sft_item_t q
);
  import sft_pkg::*;

  logic [DenW:0] rem2;
  logic [DenW:0] den;
  logic          ge;
  sft_item_t     q_next;

  always_comb begin
    q_next = d;
    rem2 = '0;
    den  = '0;
    ge   = 1'b0;
    for (int i = 0; i < Lanes; i++) begin
      den  = (i >= LaneSideX) ? {1'b0, d.root} : {1'b0, d.ls};
      rem2 = {d.rem[i], d.num[i][NumW-1]};
      ge   = (rem2 >= den);
      q_next.rem[i] = ge ? DenW'(rem2 - den) : DenW'(rem2);
      q_next.num[i] = {d.num[i][NumW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

// ----- src/segment_frame_transform.sv -----
`timescale 1ns / 1ps
// Pipeline: 3 front stages, 16 square-root cells, 32 divider cells and
// 1 output register lie between input transfer and result.
// Throughput: one transfer per cycle; the whole chain advances together
// and holds while a result waits under result_stall.
// Reset: synchronous rst clears all valid flags; data registers are not reset.
module segment_frame_transform (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               stall,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] start_z,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  input  logic signed [15:0] end_z,
  input  logic [15:0]        length_scale,
  input  logic [15:0]        width_scale,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [28:0] dir_x,
  output logic signed [28:0] dir_y,
  output logic signed [16:0] dir_z,
  output logic signed [31:0] side_x,
  output logic signed [31:0] side_y,
  output logic signed [23:0] mid_x,
  output logic signed [23:0] mid_y,
  output logic signed [19:0] mid_z,
  output logic               divide_error
);
  import sft_pkg::*;

  logic      en;
  sft_item_t sq_chain [SqCells+1];
  sft_item_t dv_chain [DivCells+1];
  sft_item_t fin;
  logic      ls_zero, root_zero;
  logic [NumW-1:0] res [Lanes];

  assign en    = !(result_valid && result_stall);
  assign stall = !en;

  sft_front u_front (
    .clk, .rst, .en, .valid,
    .start_x, .start_y, .start_z, .end_x, .end_y, .end_z,
    .length_scale, .width_scale,
    .item(sq_chain[0])
  );

  for (genvar g = 0; g < SqCells; g++) begin : g_sqrt
    sft_sqrt_cell u_cell (.clk, .rst, .en, .d(sq_chain[g]), .q(sq_chain[g+1]));
  end

  assign dv_chain[0] = sq_chain[SqCells];

  for (genvar g = 0; g < DivCells; g++) begin : g_div
    sft_div_cell u_cell (.clk, .rst, .en, .d(dv_chain[g]), .q(dv_chain[g+1]));
  end

  assign fin       = dv_chain[DivCells];
  assign ls_zero   = (fin.ls == '0);
  assign root_zero = (fin.root == '0);

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      res[i] = fin.neg[i] ? NumW'(0) - fin.num[i] : fin.num[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= fin.vld;
    end
    if (en) begin
      dir_x  <= ls_zero ? '0 : 29'(res[LaneDirX]);
      dir_y  <= ls_zero ? '0 : 29'(res[LaneDirY]);
      dir_z  <= ls_zero ? '0 : 17'(res[LaneDirZ]);
      side_x <= root_zero ? '0 : res[LaneSideX];
      side_y <= root_zero ? '0 : res[LaneSideY];
      mid_x  <= fin.mid_x;
      mid_y  <= fin.mid_y;
      mid_z  <= fin.mid_z;
      divide_error <= ls_zero || root_zero;
    end
  end

endmodule

// ----- src/sft_checker.sv -----
`timescale 1ns / 1ps
module sft_checker (
  input logic               clk,
  input logic               rst,
  input logic               stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [28:0] dir_x,
  input logic signed [31:0] side_x,
  input logic signed [23:0] mid_x,
  input logic signed [23:0] mid_y,
  input logic signed [19:0] mid_z,
  input logic               divide_error
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(dir_x) && $stable(side_x)
      && $stable(divide_error))
    else $error("result changed while stalled");

  a_no_backpressure: assert property (@(posedge clk) disable iff (rst)
    !(result_valid && result_stall) |-> !stall)
    else $error("input stalled with free output");

  a_mid_scaled: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> mid_x[7:0] == 8'd0 && mid_y[7:0] == 8'd0 && mid_z[3:0] == 4'd0)
    else $error("midpoint not scaled");

endmodule

bind segment_frame_transform sft_checker u_sft_checker (
  .clk, .rst, .stall, .result_valid, .result_stall,
  .dir_x, .side_x, .mid_x, .mid_y, .mid_z, .divide_error
);
